FILE: rtl/tlfq_pkg.sv
// Package for the three-level feedback queue scheduler.
// Payload structs, command and status codes, controller/datapath interface.
// No dependencies.
package tlfq_pkg;

    localparam int unsigned QUANTUM_RESET   = 50;
    localparam int unsigned ALLOTMENT_RESET = 200;
    localparam int unsigned SPENT_BITS      = 21;

    typedef enum logic [1:0] {
        CMD_ADMIT = 2'd0,
        CMD_SLICE = 2'd1,
        CMD_BOOST = 2'd2,
        CMD_NONE  = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        ST_ADMITTED = 3'd0,
        ST_REJECTED = 3'd1,
        ST_REQUEUED = 3'd2,
        ST_FINISHED = 3'd3,
        ST_IDLE     = 3'd4,
        ST_BOOSTED  = 3'd5
    } status_t;

    typedef enum logic [0:0] {
        REG_QUANTUM   = 1'b0,
        REG_ALLOTMENT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  task_slot;
        logic [1:0]  task_type;
        logic [19:0] task_length;
        logic [6:0]  io_odds;
        logic [6:0]  io_roll;
        logic [15:0] io_draw;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  out_slot;
        logic [1:0]  out_type;
        logic [19:0] slice_time;
        logic        took_io;
        logic [1:0]  new_level;
        logic [19:0] remaining;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch input transaction
        logic rd;         // read records of the selected slot
        logic calc;       // compute run time (start divider)
        logic commit;     // write back the slice
        logic admit;      // write back an admit
        logic link_rd;    // read the link of the lower queue head
        logic boost_step; // move one task of a lower queue to the top
        logic emit;       // load the output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       admit_ok;
        logic       any_task;
        logic       div_busy;
        logic       boost_more;
        logic [1:0] command;
    } dp_status_t;

endpackage

FILE: rtl/tlfq_ctrl.sv
// Controller state machine for the feedback queue scheduler.
// Depends on tlfq_pkg.
module tlfq_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    out_full,
    input  tlfq_pkg::dp_status_t    sts,
    output tlfq_pkg::dp_cmd_t       cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_DEC    = 8'b00000010,
        S_READ   = 8'b00000100,
        S_CALC   = 8'b00001000,
        S_DIV    = 8'b00010000,
        S_BOOST  = 8'b00100000,
        S_BMOVE  = 8'b01000000,
        S_EMIT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                unique case (tlfq_pkg::command_t'(sts.command))
                    tlfq_pkg::CMD_ADMIT:
                    begin
                        cmd.admit = sts.admit_ok;
                        state_next = S_EMIT;
                    end
                    tlfq_pkg::CMD_SLICE:
                    begin
                        cmd.rd = 1'b1;
                        state_next = sts.any_task ? S_READ : S_EMIT;
                    end
                    tlfq_pkg::CMD_BOOST: state_next = S_BOOST;
                    default:             state_next = S_IDLE;
                endcase
            end
            S_READ:
            begin
                cmd.calc = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.commit = 1'b1;
                state_next = S_EMIT;
            end
            S_BOOST:
            begin
                if (sts.boost_more)
                begin
                    cmd.link_rd = 1'b1;
                    state_next = S_BMOVE;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_BMOVE:
            begin
                cmd.boost_step = 1'b1;
                state_next = S_BOOST;
            end
            S_EMIT:
            begin
                if (!out_full)
                begin
                    cmd.emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/tlfq_dp.sv
// Datapath of the feedback queue scheduler: slot records, linked queues,
// bit-serial remainder unit and result assembly. Depends on tlfq_pkg.
module tlfq_dp
#(
    parameter int unsigned TASK_SLOTS  = 64,
    parameter int unsigned LENGTH_BITS = 20
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  tlfq_pkg::in_item_t      in_item,
    input  logic [15:0]             quantum,
    input  logic [19:0]             allotment,
    input  tlfq_pkg::dp_cmd_t       cmd,
    output tlfq_pkg::dp_status_t    sts,
    output tlfq_pkg::out_item_t     res
);

    localparam int unsigned SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int unsigned SB = tlfq_pkg::SPENT_BITS;
    localparam logic [SB-1:0] SPENT_MAX = {SB{1'b1}};

    logic [LENGTH_BITS-1:0] rem_mem [TASK_SLOTS];
    logic [1:0]             lvl_mem [TASK_SLOTS];
    logic [SB-1:0]          spent_mem [TASK_SLOTS];
    logic [1:0]             type_mem [TASK_SLOTS];
    logic [6:0]             odds_mem [TASK_SLOTS];
    logic [SW-1:0]          link_mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0]  busy_reg;

    logic [SW-1:0] head_reg [3];
    logic [SW-1:0] tail_reg [3];
    logic [2:0]    ne_reg;

    tlfq_pkg::in_item_t     it_reg;
    tlfq_pkg::out_item_t    res_reg;
    tlfq_pkg::out_item_t    res_next;

    logic [SW-1:0]          s_reg;
    logic [1:0]             l_reg;
    logic [LENGTH_BITS-1:0] rrem_reg;
    logic [1:0]             rlvl_reg;
    logic [SB-1:0]          rspent_reg;
    logic [1:0]             rtype_reg;
    logic [6:0]             rodds_reg;
    logic [SW-1:0]          rlink_reg;

    // remainder unit
    logic [LENGTH_BITS-1:0] lim_reg;
    logic [LENGTH_BITS:0]   part_reg;
    logic [15:0]            dvd_reg;
    logic [4:0]             cnt_reg;
    logic                   dbusy_reg;

    // latched slice result
    logic                   rspent_ok_admit;
    logic                   slice_done;
    logic                   fin_reg;
    logic                   io_reg;
    logic [1:0]             lvl_reg2;
    logic [LENGTH_BITS-1:0] run_reg;
    logic [LENGTH_BITS-1:0] rem_reg2;

    // queue after pop of level l is non-empty at level m?
    function automatic logic ne_next_pop(input logic [1:0] l, input logic [1:0] m);
        logic r;
        r = ne_reg[m];
        if (l == m && head_reg[l] == tail_reg[l])
        begin
            r = 1'b0;
        end
        return r;
    endfunction

    // widen the 20-bit length to LENGTH_BITS
    logic [LENGTH_BITS-1:0] len_in;
    always_comb
    begin
        len_in = '0;
        for (int i = 0; i < LENGTH_BITS && i < 20; i++)
        begin
            len_in[i] = it_reg.task_length[i];
        end
    end

    logic [LENGTH_BITS-1:0] q_eff;
    assign q_eff = (quantum == 16'd0) ? LENGTH_BITS'(1) :
        ((LENGTH_BITS >= 16) ? LENGTH_BITS'(quantum) : (|(quantum >> LENGTH_BITS) ?
        {LENGTH_BITS{1'b1}} : LENGTH_BITS'(quantum)));

    logic slot_ok;
    assign slot_ok = (32'(it_reg.task_slot) < TASK_SLOTS);
    logic [SW-1:0] islot;
    assign islot = SW'(it_reg.task_slot);
    assign sts.admit_ok = (it_reg.task_length != 20'd0) && (len_in != '0) && slot_ok
                          && !busy_reg[islot];
    assign sts.any_task = |ne_reg;
    assign sts.div_busy = dbusy_reg;
    assign sts.boost_more = ne_reg[1] | ne_reg[2];
    assign sts.command = it_reg.command;
    assign res = res_reg;

    // slice arithmetic
    logic io;
    assign io = (it_reg.io_roll <= rodds_reg);
    logic [LENGTH_BITS-1:0] run, rem_new;
    logic fin;
    always_comb
    begin
        if (!io)
        begin
            if (rrem_reg <= q_eff)
            begin
                run = rrem_reg;
            end
            else
            begin
                run = q_eff;
            end
        end
        else
        begin
            run = part_reg[LENGTH_BITS-1:0] + LENGTH_BITS'(1);
            if (run > rrem_reg)
            begin
                run = rrem_reg;
            end
        end
        rem_new = rrem_reg - run;
        fin = (rem_new == '0);
    end

    logic [SB:0] sp_sum;
    logic [SB-1:0] sp;
    logic demote;
    logic [1:0] lvl_new;
    logic [SB-1:0] spent_new;
    always_comb
    begin
        sp_sum = {1'b0, rspent_reg} + (SB+1)'(run);
        sp = sp_sum[SB] ? SPENT_MAX : sp_sum[SB-1:0];
        demote = (rlvl_reg < 2'd2) && (sp > SB'(allotment));
        lvl_new = rlvl_reg;
        spent_new = rspent_reg;
        if (io || !fin)
        begin
            spent_new = demote ? '0 : sp;
            lvl_new = demote ? rlvl_reg + 2'd1 : rlvl_reg;
        end
    end

    // highest non-empty level
    logic [1:0] top_lvl;
    always_comb
    begin
        if (ne_reg[0])      top_lvl = 2'd0;
        else if (ne_reg[1]) top_lvl = 2'd1;
        else                top_lvl = 2'd2;
    end
    logic [1:0] blvl;
    assign blvl = ne_reg[1] ? 2'd1 : 2'd2;

    // result assembly
    always_comb
    begin
        res_next = '0;
        unique case (tlfq_pkg::command_t'(it_reg.command))
            tlfq_pkg::CMD_ADMIT:
            begin
                res_next.out_slot = it_reg.task_slot;
                res_next.out_type = it_reg.task_type;
                if (rspent_ok_admit)
                begin
                    res_next.status    = tlfq_pkg::ST_ADMITTED;
                    res_next.remaining = 20'(len_in);
                end
                else
                begin
                    res_next.status = tlfq_pkg::ST_REJECTED;
                end
            end
            tlfq_pkg::CMD_SLICE:
            begin
                if (slice_done)
                begin
                    res_next.status     = fin_reg ? tlfq_pkg::ST_FINISHED
                                                  : tlfq_pkg::ST_REQUEUED;
                    res_next.out_slot   = 6'(s_reg);
                    res_next.out_type   = rtype_reg;
                    res_next.slice_time = 20'(run_reg);
                    res_next.took_io    = io_reg;
                    res_next.new_level  = lvl_reg2;
                    res_next.remaining  = 20'(rem_reg2);
                end
                else
                begin
                    res_next.status = tlfq_pkg::ST_IDLE;
                end
            end
            default: res_next.status = tlfq_pkg::ST_BOOSTED;
        endcase
    end

    // payload and memories
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            it_reg <= in_item;
        end
        if (cmd.rd)
        begin
            s_reg      <= head_reg[top_lvl];
            l_reg      <= top_lvl;
            rrem_reg   <= rem_mem[head_reg[top_lvl]];
            rlvl_reg   <= lvl_mem[head_reg[top_lvl]];
            rspent_reg <= spent_mem[head_reg[top_lvl]];
            rtype_reg  <= type_mem[head_reg[top_lvl]];
            rodds_reg  <= odds_mem[head_reg[top_lvl]];
            rlink_reg  <= link_mem[head_reg[top_lvl]];
        end
        if (cmd.link_rd)
        begin
            rlink_reg <= link_mem[head_reg[blvl]];
        end
        if (cmd.admit)
        begin
            rem_mem[islot]   <= len_in;
            lvl_mem[islot]   <= 2'd0;
            spent_mem[islot] <= '0;
            type_mem[islot]  <= it_reg.task_type;
            odds_mem[islot]  <= it_reg.io_odds;
            if (ne_reg[0])
            begin
                link_mem[tail_reg[0]] <= islot;
            end
        end
        if (cmd.commit)
        begin
            rem_mem[s_reg]   <= rem_new;
            lvl_mem[s_reg]   <= lvl_new;
            spent_mem[s_reg] <= spent_new;
            if (!fin && ne_next_pop(l_reg, lvl_new))
            begin
                link_mem[tail_reg[lvl_new]] <= s_reg;
            end
        end
        if (cmd.boost_step)
        begin
            lvl_mem[head_reg[blvl]]   <= 2'd0;
            spent_mem[head_reg[blvl]] <= '0;
            if (ne_reg[0])
            begin
                link_mem[tail_reg[0]] <= head_reg[blvl];
            end
        end
        if (cmd.emit)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            slice_done <= 1'b0;
        end
        if (cmd.admit)
        begin
            rspent_ok_admit <= 1'b1;
        end
        else if (cmd.load)
        begin
            rspent_ok_admit <= 1'b0;
        end
        if (cmd.commit)
        begin
            slice_done <= 1'b1;
            fin_reg    <= fin;
            io_reg     <= io;
            lvl_reg2   <= lvl_new;
            run_reg    <= run;
            rem_reg2   <= rem_new;
        end
    end

    // control state: busy bits, queue pointers, remainder unit
    logic [LENGTH_BITS:0] trial;
    assign trial = {part_reg[LENGTH_BITS-1:0], dvd_reg[15]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= '0;
            ne_reg    <= '0;
            dbusy_reg <= 1'b0;
            cnt_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.admit)
            begin
                busy_reg[islot] <= 1'b1;
                if (!ne_reg[0])
                begin
                    head_reg[0] <= islot;
                end
                tail_reg[0] <= islot;
                ne_reg[0]   <= 1'b1;
            end
            if (cmd.calc)
            begin
                dbusy_reg <= 1'b1;
                cnt_reg   <= 5'd16;
            end
            else if (dbusy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    dbusy_reg <= 1'b0;
                end
            end
            if (cmd.commit)
            begin
                if (fin)
                begin
                    busy_reg[s_reg] <= 1'b0;
                end
                if (head_reg[l_reg] == tail_reg[l_reg])
                begin
                    // a lone task requeued on its own level keeps the queue live
                    if (fin || lvl_new != l_reg)
                    begin
                        ne_reg[l_reg] <= 1'b0;
                    end
                end
                else
                begin
                    head_reg[l_reg] <= rlink_reg;
                end
                if (!fin)
                begin
                    if (!ne_next_pop(l_reg, lvl_new))
                    begin
                        head_reg[lvl_new] <= s_reg;
                    end
                    tail_reg[lvl_new] <= s_reg;
                    ne_reg[lvl_new]   <= 1'b1;
                end
            end
            if (cmd.boost_step)
            begin
                if (head_reg[blvl] == tail_reg[blvl])
                begin
                    ne_reg[blvl] <= 1'b0;
                end
                else
                begin
                    head_reg[blvl] <= rlink_reg;
                end
                if (!ne_reg[0])
                begin
                    head_reg[0] <= head_reg[blvl];
                end
                tail_reg[0] <= head_reg[blvl];
                ne_reg[0]   <= 1'b1;
            end
        end
    end

    // restoring remainder: draw mod min(rem, q)
    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            lim_reg  <= (rrem_reg < q_eff) ? ((rrem_reg == '0) ? LENGTH_BITS'(1) : rrem_reg)
                                           : q_eff;
            part_reg <= '0;
            dvd_reg  <= it_reg.io_draw;
        end
        else if (dbusy_reg)
        begin
            dvd_reg <= {dvd_reg[14:0], 1'b0};
            if (trial >= {1'b0, lim_reg})
            begin
                part_reg <= trial - {1'b0, lim_reg};
            end
            else
            begin
                part_reg <= trial;
            end
        end
    end

endmodule

FILE: rtl/three_level_feedback_queue_scheduler.sv
// Top level of the three-level feedback queue scheduler.
// Depends on tlfq_pkg, tlfq_ctrl and tlfq_dp.
//
// One transaction at a time. An admit, a rejected admit or a slice with no
// task ready goes through decode and result; a slice through decode, record
// read, the 16-step bit-serial remainder of the IO draw, which runs on every
// slice, then write-back and result; a boost moves the tasks of the lower
// queues one at a time before its result; command three gives no result.
// The result is held in an output register until taken; while it waits the
// next transaction stalls in its last cycle. No clearing pass after reset.
module three_level_feedback_queue_scheduler
#(
    parameter int unsigned TASK_SLOTS  = 64,
    parameter int unsigned LENGTH_BITS = 20
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  tlfq_pkg::in_item_t      in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output tlfq_pkg::out_item_t     out_data,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    tlfq_pkg::dp_cmd_t    cmd;
    tlfq_pkg::dp_status_t sts;
    logic [15:0] quantum_reg;
    logic [19:0] allotment_reg;
    logic        ovalid_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg   <= 16'(tlfq_pkg::QUANTUM_RESET);
            allotment_reg <= 20'(tlfq_pkg::ALLOTMENT_RESET);
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0)
        begin
            if (paddr[2] == tlfq_pkg::REG_QUANTUM)
            begin
                quantum_reg <= pwdata[15:0];
            end
            else
            begin
                allotment_reg <= pwdata[19:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == tlfq_pkg::REG_QUANTUM)
        begin
            prdata[15:0] = quantum_reg;
        end
        else
        begin
            prdata[19:0] = allotment_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            ovalid_reg <= 1'b0;
        end
    end
    assign out_valid = ovalid_reg;

    tlfq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_full (ovalid_reg && out_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    tlfq_dp #(.TASK_SLOTS(TASK_SLOTS), .LENGTH_BITS(LENGTH_BITS)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_data),
        .quantum   (quantum_reg),
        .allotment (allotment_reg),
        .cmd       (cmd),
        .sts       (sts),
        .res       (out_data)
    );

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.admit, cmd.commit, cmd.boost_step, cmd.emit}))
        else $error("overlapping datapath commands");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(ovalid_reg && out_stall))
        else $error("result overwritten");
    a_busy_in: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> in_stall)
        else $error("input taken while busy");

endmodule

FILE: verif/tb_three_level_feedback_queue_scheduler.sv
// Testbench for the three-level feedback queue scheduler: directed and random
// admit/slice/boost traffic checked against a behavioural scheduler model.
// Depends on tlfq_pkg and three_level_feedback_queue_scheduler.
`timescale 1ns / 1ps

class sched_scoreboard;
    localparam int SLOTS = 64;
    localparam int unsigned SPENT_SAT = 21'h1FFFFF;

    bit [15:0] quantum;
    bit [19:0] allotment;
    bit [19:0] task_rem [SLOTS];
    bit [1:0]  task_lvl [SLOTS];
    bit [20:0] task_spent [SLOTS];
    bit [1:0]  task_cls [SLOTS];
    bit [6:0]  task_odds [SLOTS];
    bit        busy [SLOTS];
    int        ready_q [3][$];
    tlfq_pkg::out_item_t pending [$];
    int        errors;
    int        n_checked;
    int        n_status [6];

    function void clear();
        quantum = 16'(tlfq_pkg::QUANTUM_RESET);
        allotment = 20'(tlfq_pkg::ALLOTMENT_RESET);
        for (int i = 0; i < SLOTS; i++)
            busy[i] = 1'b0;
        for (int l = 0; l < 3; l++)
            ready_q[l].delete();
        pending.delete();
    endfunction

    function int live_tasks();
        return ready_q[0].size() + ready_q[1].size() + ready_q[2].size();
    endfunction

    function void note_input(tlfq_pkg::in_item_t it);
        tlfq_pkg::out_item_t r;
        int s;
        int lvl;
        bit [19:0] q;
        bit [19:0] lim;
        bit [19:0] run;
        bit [19:0] rem;
        bit io;
        bit done;
        int unsigned sp;
        r = '0;
        case (tlfq_pkg::command_t'(it.command))
            tlfq_pkg::CMD_ADMIT:
            begin
                s = it.task_slot;
                r.out_slot = it.task_slot;
                r.out_type = it.task_type;
                if (it.task_length == 0 || busy[s])
                    r.status = tlfq_pkg::ST_REJECTED;
                else
                begin
                    task_rem[s] = it.task_length;
                    task_lvl[s] = 0;
                    task_spent[s] = 0;
                    task_cls[s] = it.task_type;
                    task_odds[s] = it.io_odds;
                    busy[s] = 1'b1;
                    ready_q[0].push_back(s);
                    r.status = tlfq_pkg::ST_ADMITTED;
                    r.remaining = it.task_length;
                end
            end
            tlfq_pkg::CMD_SLICE:
            begin
                lvl = 0;
                while (lvl < 3 && ready_q[lvl].size() == 0)
                    lvl++;
                if (lvl == 3)
                    r.status = tlfq_pkg::ST_IDLE;
                else
                begin
                    s = ready_q[lvl].pop_front();
                    q = (quantum == 0) ? 20'd1 : 20'(quantum);
                    rem = task_rem[s];
                    io = it.io_roll <= task_odds[s];
                    if (!io)
                    begin
                        run = (rem <= q) ? rem : q;
                        rem = rem - run;
                        done = (rem == 0);
                    end
                    else
                    begin
                        lim = (rem < q) ? rem : q;
                        if (lim == 0)
                            lim = 1;
                        run = 20'(32'(it.io_draw) % 32'(lim)) + 20'd1;
                        if (run > rem)
                            run = rem;
                        rem = rem - run;
                        done = (rem == 0);
                    end
                    task_rem[s] = rem;
                    if (io || !done)
                    begin
                        sp = task_spent[s] + run;
                        if (sp > SPENT_SAT)
                            sp = SPENT_SAT;
                        task_spent[s] = 21'(sp);
                        if (task_lvl[s] < 2 && sp > allotment)
                        begin
                            task_lvl[s]++;
                            task_spent[s] = 0;
                        end
                    end
                    if (done)
                        busy[s] = 1'b0;
                    else
                        ready_q[task_lvl[s]].push_back(s);
                    r.status = done ? tlfq_pkg::ST_FINISHED : tlfq_pkg::ST_REQUEUED;
                    r.out_slot = 6'(s);
                    r.out_type = task_cls[s];
                    r.slice_time = run;
                    r.took_io = io;
                    r.new_level = task_lvl[s];
                    r.remaining = rem;
                end
            end
            tlfq_pkg::CMD_BOOST:
            begin
                for (int l = 1; l < 3; l++)
                    while (ready_q[l].size() != 0)
                    begin
                        s = ready_q[l].pop_front();
                        task_lvl[s] = 0;
                        task_spent[s] = 0;
                        ready_q[0].push_back(s);
                    end
                r.status = tlfq_pkg::ST_BOOSTED;
            end
            default:
                return;
        endcase
        pending.push_back(r);
    endfunction

    function void check_result(tlfq_pkg::out_item_t got);
        tlfq_pkg::out_item_t e;
        if (pending.size() == 0)
        begin
            $error("result with nothing outstanding: status %0d", got.status);
            errors++;
            return;
        end
        e = pending.pop_front();
        n_checked++;
        if (e.status < 6)
            n_status[e.status]++;
        if (got.status !== e.status)
        begin
            $error("status exp %0d got %0d", e.status, got.status);
            errors++;
        end
        if (got.out_slot !== e.out_slot)
        begin
            $error("out_slot exp %0d got %0d", e.out_slot, got.out_slot);
            errors++;
        end
        if (got.out_type !== e.out_type)
        begin
            $error("out_type exp %0d got %0d", e.out_type, got.out_type);
            errors++;
        end
        if (got.slice_time !== e.slice_time)
        begin
            $error("slice_time exp %0d got %0d", e.slice_time, got.slice_time);
            errors++;
        end
        if (got.took_io !== e.took_io)
        begin
            $error("took_io exp %0d got %0d", e.took_io, got.took_io);
            errors++;
        end
        if (got.new_level !== e.new_level)
        begin
            $error("new_level exp %0d got %0d", e.new_level, got.new_level);
            errors++;
        end
        if (got.remaining !== e.remaining)
        begin
            $error("remaining exp %0d got %0d", e.remaining, got.remaining);
            errors++;
        end
    endfunction
endclass

module tb_three_level_feedback_queue_scheduler;
    localparam int WATCHDOG = 20000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    tlfq_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_stall;
    tlfq_pkg::out_item_t out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    sched_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    int  quiet_cycles;
    int  n_sent;

    three_level_feedback_queue_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random stall, long hold-off on request
    initial
    begin
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_result(out_data);
            out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else if (rst_n && !hold_off)
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // valid stays high after acceptance; the next send or drain sets it
    task automatic send(tlfq_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(it);
        n_sent++;
    endtask

    task automatic reg_write(tlfq_pkg::reg_index_t idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == tlfq_pkg::REG_QUANTUM)
            sb.quantum = val[15:0];
        else
            sb.allotment = val[19:0];
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic tlfq_pkg::in_item_t mk(tlfq_pkg::command_t c, int slot, int len,
                                              int odds, int roll, int draw);
        tlfq_pkg::in_item_t it;
        it.command = c;
        it.task_slot = 6'(slot);
        it.task_type = 2'($urandom_range(3));
        it.task_length = 20'(len);
        it.io_odds = 7'(odds);
        it.io_roll = 7'(roll);
        it.io_draw = 16'(draw);
        return it;
    endfunction

    function automatic tlfq_pkg::in_item_t rand_item();
        int k;
        int len;
        k = $urandom_range(99);
        len = ($urandom_range(19) == 0) ? $urandom_range(20'hFFFFF)
                                        : $urandom_range(1, 400);
        if ($urandom_range(30) == 0)
            len = 0;
        if (k < 38 && sb.live_tasks() < 40)
            return mk(tlfq_pkg::CMD_ADMIT, $urandom_range(63), len, $urandom_range(100),
                      $urandom_range(99), $urandom());
        else if (k < 92)
            return mk(tlfq_pkg::CMD_SLICE, $urandom_range(63), $urandom(),
                      $urandom_range(127), $urandom_range(99), $urandom());
        else if (k < 97)
            return mk(tlfq_pkg::CMD_BOOST, $urandom_range(63), $urandom(),
                      $urandom_range(127), $urandom_range(127), $urandom());
        return mk(tlfq_pkg::CMD_NONE, $urandom_range(63), $urandom(), $urandom_range(127),
                  $urandom_range(127), $urandom());
    endfunction

    initial
    begin
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_off = 1'b0;
        n_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty slice, rejects, extremes, IO paths, demotion, boost
        send(mk(tlfq_pkg::CMD_SLICE, 0, 0, 0, 0, 0));
        send(mk(tlfq_pkg::CMD_BOOST, 0, 0, 0, 0, 0));
        send(mk(tlfq_pkg::CMD_ADMIT, 5, 0, 50, 0, 0));
        send(mk(tlfq_pkg::CMD_ADMIT, 0, 20'hFFFFF, 0, 0, 0));
        send(mk(tlfq_pkg::CMD_ADMIT, 0, 10, 0, 0, 0));
        send(mk(tlfq_pkg::CMD_ADMIT, 63, 1, 100, 0, 0));
        send(mk(tlfq_pkg::CMD_ADMIT, 42, 300, 100, 0, 0));
        send(mk(tlfq_pkg::CMD_NONE, 7, 7, 7, 7, 7));
        send(mk(tlfq_pkg::CMD_SLICE, 0, 0, 0, 99, 16'hFFFF));
        send(mk(tlfq_pkg::CMD_SLICE, 0, 0, 0, 0, 16'hFFFF));
        send(mk(tlfq_pkg::CMD_SLICE, 0, 0, 0, 0, 0));
        for (int i = 0; i < 8; i++)
            send(mk(tlfq_pkg::CMD_SLICE, 0, 0, 0, 99, 0));
        send(mk(tlfq_pkg::CMD_BOOST, 0, 0, 0, 0, 0));
        for (int i = 0; i < 4; i++)
            send(mk(tlfq_pkg::CMD_SLICE, 0, 0, 0, 0, $urandom()));
        drain();

        reg_write(tlfq_pkg::REG_QUANTUM, 32'd0);
        reg_write(tlfq_pkg::REG_ALLOTMENT, 32'd0);
        send(mk(tlfq_pkg::CMD_ADMIT, 9, 5, 100, 0, 0));
        for (int i = 0; i < 5; i++)
            send(mk(tlfq_pkg::CMD_SLICE, 0, 0, 0, 0, $urandom()));
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 57 : 0;
            recv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 31 : 0;
            for (int c = 0; c < 3; c++)
            begin
                drain();
                case (c)
                    0:
                    begin
                        reg_write(tlfq_pkg::REG_QUANTUM, 32'd65535);
                        reg_write(tlfq_pkg::REG_ALLOTMENT, 32'hFFFFF);
                    end
                    1:
                    begin
                        reg_write(tlfq_pkg::REG_QUANTUM, $urandom_range(1, 60));
                        reg_write(tlfq_pkg::REG_ALLOTMENT, $urandom_range(0, 300));
                    end
                    default:
                    begin
                        reg_write(tlfq_pkg::REG_QUANTUM, 32'd1);
                        reg_write(tlfq_pkg::REG_ALLOTMENT, $urandom_range(0, 20));
                    end
                endcase
                if (ph == 2 && c == 0)
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (400) @(posedge clk);
                            hold_off = 1'b0;
                        end
                    join_none
                for (int i = 0; i < 155; i++)
                    send(rand_item());
            end
        end

        drain();
        $display("%0d transactions sent, %0d results checked", n_sent, sb.n_checked);
        $display("admitted %0d rejected %0d requeued %0d finished %0d idle %0d boosted %0d",
                 sb.n_status[tlfq_pkg::ST_ADMITTED], sb.n_status[tlfq_pkg::ST_REJECTED],
                 sb.n_status[tlfq_pkg::ST_REQUEUED], sb.n_status[tlfq_pkg::ST_FINISHED],
                 sb.n_status[tlfq_pkg::ST_IDLE], sb.n_status[tlfq_pkg::ST_BOOSTED]);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
